### hdl/aqc_pkg.sv
// shared widths, reset values and register indexes for the quantum calibrator
`default_nettype none

package aqc_pkg;

  // field widths
  localparam int unsigned CLOCK_W   = 32;
  localparam int unsigned QUANTUM_W = 17;
  localparam int unsigned TARGET_W  = 15;
  localparam int unsigned VISITS_W  = 7;
  localparam int unsigned TOTAL_W   = 64;
  localparam int unsigned PRELOAD_W = 16;
  localparam int unsigned PRODUCT_W = QUANTUM_W + TARGET_W;

  // digit-serial accumulator geometry
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned DIGITS    = TOTAL_W / DIGIT_W;
  localparam int unsigned DIGIT_CNT_W = $clog2(DIGITS);

  // iteration counters of the shift-add and shift-subtract units
  localparam int unsigned MUL_CNT_W = $clog2(TARGET_W);
  localparam int unsigned DIV_CNT_W = $clog2(CLOCK_W);

  // reset values
  localparam logic [TARGET_W-1:0]  TARGET_RESET  = TARGET_W'(1000);
  localparam logic [QUANTUM_W-1:0] FLOOR_RESET   = QUANTUM_W'(256);
  localparam logic [QUANTUM_W-1:0] CEILING_RESET = QUANTUM_W'(65536);
  localparam logic [VISITS_W-1:0]  VISITS_RESET  = VISITS_W'(64);
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(8192);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TARGET  = 2'd0,
    CFG_FLOOR   = 2'd1,
    CFG_CEILING = 2'd2,
    CFG_VISITS  = 2'd3
  } cfg_index_t;

endpackage

`default_nettype wire

### hdl/aqc_serial_acc.sv
// digit-serial 64-bit opcode total, one 4-bit digit per cycle
`default_nettype none

module aqc_serial_acc (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [aqc_pkg::QUANTUM_W-1:0]  addend_in,
  output logic                                done,
  output logic [aqc_pkg::TOTAL_W-1:0]         total
);

  logic [aqc_pkg::TOTAL_W-1:0]     sum;
  logic [aqc_pkg::TOTAL_W-1:0]     addend;
  logic                            carry;
  logic [aqc_pkg::DIGIT_CNT_W-1:0] count;
  logic                            busy;
  logic [aqc_pkg::DIGIT_W:0]       digit_sum;

  // one digit of the add, low digit first
  assign digit_sum = {1'b0, sum[aqc_pkg::DIGIT_W-1:0]}
                   + {1'b0, addend[aqc_pkg::DIGIT_W-1:0]}
                   + {{aqc_pkg::DIGIT_W{1'b0}}, carry};

  // rotate the total through the adder, shift the addend out beside it
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
      carry <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        addend <= {{(aqc_pkg::TOTAL_W - aqc_pkg::QUANTUM_W){1'b0}}, addend_in};
        carry  <= 1'b0;
        count  <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        sum    <= {digit_sum[aqc_pkg::DIGIT_W-1:0],
                   sum[aqc_pkg::TOTAL_W-1:aqc_pkg::DIGIT_W]};
        addend <= {{aqc_pkg::DIGIT_W{1'b0}}, addend[aqc_pkg::TOTAL_W-1:aqc_pkg::DIGIT_W]};
        carry  <= digit_sum[aqc_pkg::DIGIT_W];
        count  <= count + 1'b1;
        if (count == aqc_pkg::DIGIT_CNT_W'(aqc_pkg::DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign total = sum;

endmodule

`default_nettype wire

### hdl/aqc_serial_mul.sv
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none

module aqc_serial_mul (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [aqc_pkg::QUANTUM_W-1:0]  multiplicand,
  input  wire logic [aqc_pkg::TARGET_W-1:0]   multiplier,
  output logic                                done,
  output logic [aqc_pkg::PRODUCT_W-1:0]       product
);

  logic [aqc_pkg::QUANTUM_W-1:0] mcand;
  logic [aqc_pkg::QUANTUM_W-1:0] hi;
  logic [aqc_pkg::TARGET_W-1:0]  lo;
  logic [aqc_pkg::MUL_CNT_W-1:0] count;
  logic                          busy;
  logic [aqc_pkg::QUANTUM_W:0]   part_sum;

  // add the multiplicand into the upper half when the low bit is set
  assign part_sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand <= multiplicand;
        hi    <= '0;
        lo    <= multiplier;
        count <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        hi    <= part_sum[aqc_pkg::QUANTUM_W:1];
        lo    <= {part_sum[0], lo[aqc_pkg::TARGET_W-1:1]};
        count <= count + 1'b1;
        if (count == aqc_pkg::MUL_CNT_W'(aqc_pkg::TARGET_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {hi, lo};

endmodule

`default_nettype wire

### hdl/aqc_serial_div.sv
// restoring divider, one quotient bit per cycle, shared by both divisions
`default_nettype none

module aqc_serial_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [aqc_pkg::CLOCK_W-1:0]   dividend,
  input  wire logic [aqc_pkg::CLOCK_W-1:0]   divisor,
  output logic                               done,
  output logic [aqc_pkg::CLOCK_W-1:0]        quotient
);

  logic [aqc_pkg::CLOCK_W-1:0]   rem;
  logic [aqc_pkg::CLOCK_W-1:0]   quo;
  logic [aqc_pkg::CLOCK_W-1:0]   dvs;
  logic [aqc_pkg::DIV_CNT_W-1:0] count;
  logic                          busy;
  logic [aqc_pkg::CLOCK_W:0]     trial;
  logic [aqc_pkg::CLOCK_W:0]     diff;
  logic                          fits;

  // bring down the next dividend bit and try the subtraction
  assign trial = {rem, quo[aqc_pkg::CLOCK_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
        count <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= fits ? diff[aqc_pkg::CLOCK_W-1:0] : trial[aqc_pkg::CLOCK_W-1:0];
        quo   <= {quo[aqc_pkg::CLOCK_W-2:0], fits};
        count <= count + 1'b1;
        if (count == aqc_pkg::DIV_CNT_W'(aqc_pkg::CLOCK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### hdl/adaptive_quantum_calibrator_top.sv
// top level of the adaptive quantum calibrator: sequencer, state and result register
//
// One input beat is one visit carrying clock_now. Each visit gives exactly one
// result beat: preload, quantum, opcode_total and calibrated.
// in_ready is high while the sequencer is idle and rst is low; a visit is taken
// when in_valid and in_ready are both high. The opcode total is added one 4-bit
// digit per cycle; a visit without a division then loads its result register,
// and the next visit can be taken in the cycle after that load. A calibrating
// visit with a stored time and a nonzero visit count also runs the rate division,
// one quotient bit per cycle. When the rate is nonzero the 15-step shift-add
// multiply and the gain division follow, and the quantum is updated before the
// result register loads.
// The result sits in an output register; the next visit is accepted while an
// earlier result waits. A stalled receiver holds the finished visit in the
// sequencer until the result register frees, and in_ready stays low meanwhile.
// Configuration writes land on cfg_we with no wait; write only while idle.
// Reset restores the register defaults, quantum 8192, a zero total, a zero
// visit count and no stored calibration time, and empties the result register.
`default_nettype none

module adaptive_quantum_calibrator_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [aqc_pkg::CLOCK_W-1:0]   clock_now,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [aqc_pkg::PRELOAD_W-1:0]      preload,
  output logic [aqc_pkg::QUANTUM_W-1:0]      quantum,
  output logic [aqc_pkg::TOTAL_W-1:0]        opcode_total,
  output logic                               calibrated,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [aqc_pkg::QUANTUM_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ACC      = 7'b0000010,
    S_DIV_RATE = 7'b0000100,
    S_MUL      = 7'b0001000,
    S_DIV_GAIN = 7'b0010000,
    S_UPDATE   = 7'b0100000,
    S_DONE     = 7'b1000000
  } seq_state_t;

  seq_state_t state, state_next;

  // configuration registers
  logic [aqc_pkg::TARGET_W-1:0]  target_period;
  logic [aqc_pkg::QUANTUM_W-1:0] quantum_floor;
  logic [aqc_pkg::QUANTUM_W-1:0] quantum_ceiling;
  logic [aqc_pkg::VISITS_W-1:0]  visits_per_calibration;

  // calibrator state
  logic [aqc_pkg::QUANTUM_W-1:0] current_quantum;
  logic [aqc_pkg::VISITS_W-1:0]  visits_since;
  logic [aqc_pkg::CLOCK_W-1:0]   last_calibration_time;

  // per-visit working registers
  logic [aqc_pkg::CLOCK_W-1:0]   visit_clock;
  logic [aqc_pkg::VISITS_W-1:0]  visit_count;
  logic                          visit_cal;

  logic                          accept;
  logic                          out_free;
  logic [aqc_pkg::VISITS_W-1:0]  count_next;

  // unit handshakes
  logic                          acc_done;
  logic [aqc_pkg::TOTAL_W-1:0]   acc_total;
  logic                          mul_start;
  logic                          mul_done;
  logic [aqc_pkg::PRODUCT_W-1:0] mul_product;
  logic                          div_start;
  logic                          div_done;
  logic [aqc_pkg::CLOCK_W-1:0]   div_dividend;
  logic [aqc_pkg::CLOCK_W-1:0]   div_divisor;
  logic [aqc_pkg::CLOCK_W-1:0]   div_quotient;

  // correction arithmetic
  logic [aqc_pkg::CLOCK_W:0]     avg_sum;
  logic [aqc_pkg::CLOCK_W-1:0]   wanted;
  logic [aqc_pkg::CLOCK_W-1:0]   wanted_floored;
  logic [aqc_pkg::CLOCK_W-1:0]   wanted_clamped;

  assign accept     = in_valid & in_ready;
  assign in_ready   = (state == S_IDLE) & ~rst;
  assign out_free   = ~out_valid | out_ready;
  assign count_next = visits_since + 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_period          <= aqc_pkg::TARGET_RESET;
      quantum_floor          <= aqc_pkg::FLOOR_RESET;
      quantum_ceiling        <= aqc_pkg::CEILING_RESET;
      visits_per_calibration <= aqc_pkg::VISITS_RESET;
    end else if (cfg_we) begin
      case (aqc_pkg::cfg_index_t'(cfg_index))
        aqc_pkg::CFG_TARGET:  target_period          <= cfg_data[aqc_pkg::TARGET_W-1:0];
        aqc_pkg::CFG_FLOOR:   quantum_floor          <= cfg_data;
        aqc_pkg::CFG_CEILING: quantum_ceiling        <= cfg_data;
        aqc_pkg::CFG_VISITS:  visits_per_calibration <= cfg_data[aqc_pkg::VISITS_W-1:0];
        default: ;
      endcase
    end
  end

  // operand selection for the shared divider
  always_comb begin
    if (state == S_ACC) begin
      div_dividend = visit_clock - last_calibration_time;
      div_divisor  = {{(aqc_pkg::CLOCK_W - aqc_pkg::VISITS_W){1'b0}}, visit_count};
    end else begin
      div_dividend = mul_product;
      div_divisor  = div_quotient;
    end
  end

  // average with the old quantum, then floor before ceiling
  always_comb begin
    avg_sum = {{(aqc_pkg::CLOCK_W + 1 - aqc_pkg::QUANTUM_W){1'b0}}, current_quantum}
            + {1'b0, div_quotient};
    wanted  = avg_sum[aqc_pkg::CLOCK_W:1];
    wanted_floored = wanted;
    if (wanted < {{(aqc_pkg::CLOCK_W - aqc_pkg::QUANTUM_W){1'b0}}, quantum_floor}) begin
      wanted_floored = {{(aqc_pkg::CLOCK_W - aqc_pkg::QUANTUM_W){1'b0}}, quantum_floor};
    end
    wanted_clamped = wanted_floored;
    if (wanted_floored >
        {{(aqc_pkg::CLOCK_W - aqc_pkg::QUANTUM_W){1'b0}}, quantum_ceiling}) begin
      wanted_clamped = {{(aqc_pkg::CLOCK_W - aqc_pkg::QUANTUM_W){1'b0}}, quantum_ceiling};
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_ACC;
      end
      S_ACC: begin
        if (acc_done) begin
          if (visit_cal && (last_calibration_time != '0) && (visit_count != '0)) begin
            div_start  = 1'b1;
            state_next = S_DIV_RATE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV_RATE: begin
        if (div_done) begin
          if (div_quotient != '0) begin
            mul_start  = 1'b1;
            state_next = S_MUL;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = S_DIV_GAIN;
        end
      end
      S_DIV_GAIN: begin
        if (div_done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // visit capture and calibrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_quantum       <= aqc_pkg::QUANTUM_RESET;
      visits_since          <= '0;
      last_calibration_time <= '0;
    end else begin
      if (state == S_UPDATE) begin
        current_quantum <= wanted_clamped[aqc_pkg::QUANTUM_W-1:0];
      end
      if ((state == S_DONE) && out_free) begin
        if (visit_cal) begin
          last_calibration_time <= visit_clock;
          visits_since          <= '0;
        end else begin
          visits_since <= visit_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      visit_clock <= clock_now;
      visit_count <= count_next;
      visit_cal   <= (count_next >= visits_per_calibration);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      preload      <= aqc_pkg::PRELOAD_W'(0) - current_quantum[aqc_pkg::PRELOAD_W-1:0];
      quantum      <= current_quantum;
      opcode_total <= acc_total;
      calibrated   <= visit_cal;
    end
  end

  aqc_serial_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .addend_in (current_quantum),
    .done      (acc_done),
    .total     (acc_total)
  );

  aqc_serial_mul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (current_quantum),
    .multiplier   (target_period),
    .done         (mul_done),
    .product      (mul_product)
  );

  aqc_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

`default_nettype wire

### verif/tb.sv
// testbench for the adaptive quantum calibrator: directed table, random visits, scoreboard
`timescale 1ns / 100ps

module tb;
  import aqc_pkg::*;

  typedef enum bit {ROW_VISIT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic [PRELOAD_W-1:0] preload;
    logic [QUANTUM_W-1:0] quantum;
    logic [TOTAL_W-1:0]   total;
    logic                 calibrated;
  } visit_result_t;

  typedef struct packed {
    row_kind_t            kind;
    cfg_index_t           index;
    logic [QUANTUM_W-1:0] value;
    logic [CLOCK_W-1:0]   stamp;
    bit                   known;
    visit_result_t        result;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CLOCK_W-1:0]   clock_now = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PRELOAD_W-1:0] preload;
  logic [QUANTUM_W-1:0] quantum;
  logic [TOTAL_W-1:0]   opcode_total;
  logic                 calibrated;
  logic                 cfg_we = 1'b0;
  cfg_index_t           cfg_index = CFG_TARGET;
  logic [QUANTUM_W-1:0] cfg_data = '0;

  // predictor copy of registers and state
  logic [TARGET_W-1:0]  target_reg  = TARGET_RESET;
  logic [QUANTUM_W-1:0] floor_reg   = FLOOR_RESET;
  logic [QUANTUM_W-1:0] ceiling_reg = CEILING_RESET;
  logic [VISITS_W-1:0]  cal_every   = VISITS_RESET;
  logic [QUANTUM_W-1:0] quantum_now = QUANTUM_RESET;
  logic [VISITS_W-1:0]  visit_count = '0;
  logic [CLOCK_W-1:0]   last_stamp  = '0;
  logic [TOTAL_W-1:0]   total_acc   = '0;

  visit_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int errors = 0;
  int results_seen = 0;
  int visits_offered = 0;
  int calibrations = 0;
  int quantum_moves = 0;
  int settings_used = 0;

  adaptive_quantum_calibrator_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .clock_now    (clock_now),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .preload      (preload),
    .quantum      (quantum),
    .opcode_total (opcode_total),
    .calibrated   (calibrated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hold reset from time zero, release it once
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // run ceiling
  initial begin
    #(15_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // one visit through the calibrator, updating the predictor state
  function automatic visit_result_t predict_visit(input logic [CLOCK_W-1:0] stamp);
    logic [CLOCK_W-1:0] per;
    logic [TOTAL_W-1:0] wanted;
    visit_result_t      r;
    r.calibrated = 1'b0;
    total_acc   = total_acc + TOTAL_W'(quantum_now);
    visit_count = visit_count + 1'b1;
    if (visit_count >= cal_every) begin
      r.calibrated = 1'b1;
      calibrations++;
      // a stored time of zero means never calibrated
      if (last_stamp != '0 && visit_count != '0) begin
        per = (stamp - last_stamp) / CLOCK_W'(visit_count);
        if (per != '0) begin
          wanted = TOTAL_W'(quantum_now) * TOTAL_W'(target_reg) / TOTAL_W'(per);
          wanted = (TOTAL_W'(quantum_now) + wanted) / 2;
          // floor first, then ceiling, so the ceiling wins
          if (wanted < TOTAL_W'(floor_reg)) wanted = TOTAL_W'(floor_reg);
          if (wanted > TOTAL_W'(ceiling_reg)) wanted = TOTAL_W'(ceiling_reg);
          if (wanted[QUANTUM_W-1:0] != quantum_now) quantum_moves++;
          quantum_now = wanted[QUANTUM_W-1:0];
        end
      end
      last_stamp  = stamp;
      visit_count = '0;
    end
    r.preload = PRELOAD_W'(0) - quantum_now[PRELOAD_W-1:0];
    r.quantum = quantum_now;
    r.total   = total_acc;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic add_write(input cfg_index_t index, input logic [QUANTUM_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_WRITE;
    row.index = index;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  task automatic add_visit(input logic [CLOCK_W-1:0] stamp);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_VISIT;
    row.stamp = stamp;
    directed_rows.push_back(row);
  endtask

  task automatic add_known(input logic [CLOCK_W-1:0] stamp, input logic [PRELOAD_W-1:0] pre,
                           input logic [QUANTUM_W-1:0] q, input logic [TOTAL_W-1:0] total,
                           input logic cal);
    stim_row_t row;
    row = '0;
    row.kind   = ROW_VISIT;
    row.stamp  = stamp;
    row.known  = 1'b1;
    row.result = '{preload: pre, quantum: q, total: total, calibrated: cal};
    directed_rows.push_back(row);
  endtask

  // drain everything outstanding before a register write
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    settings_used++;
  endtask

  // register write; the caller lowers cfg_we after the last one
  task automatic write_reg(input cfg_index_t index, input logic [QUANTUM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      CFG_TARGET:  target_reg  = value[TARGET_W-1:0];
      CFG_FLOOR:   floor_reg   = value;
      CFG_CEILING: ceiling_reg = value;
      CFG_VISITS:  cal_every   = value[VISITS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one visit beat and hold it until taken
  task automatic offer_visit(input logic [CLOCK_W-1:0] stamp, input bit known,
                             input visit_result_t typed_result);
    visit_result_t predicted;
    int            gap;
    predicted = predict_visit(stamp);
    pending_results.push_back(known ? typed_result : predicted);
    visits_offered++;
    in_valid  <= 1'b1;
    clock_now <= stamp;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stimulus: directed table, then random phases
  initial begin : stimulus
    stim_row_t            row;
    logic [QUANTUM_W-1:0] t, f, c, v;
    logic [CLOCK_W-1:0]   wall, stamp;
    int                   roll;

    // after reset: plain accumulation, no calibration yet
    add_known(32'd0,  16'd57344, 17'd8192, 64'd8192,  1'b0);
    add_known(32'd5,  16'd57344, 17'd8192, 64'd16384, 1'b0);
    add_known(32'd10, 16'd57344, 17'd8192, 64'd24576, 1'b0);
    // count register dropped below the running count; first calibration stores the clock
    add_write(CFG_VISITS, 17'd2);
    add_known(32'd1000, 16'd57344, 17'd8192, 64'd32768, 1'b1);
    // no time passed, so the per-visit figure is zero and the quantum holds
    add_write(CFG_VISITS, 17'd1);
    add_known(32'd1000, 16'd57344, 17'd8192, 64'd40960, 1'b1);
    add_visit(32'd2000);
    // very fast visits: large product, clamped at the ceiling
    add_visit(32'd2001);
    add_write(CFG_TARGET, 17'd32767);
    add_visit(32'd2002);
    // clock reads zero, wrapping difference; next calibration counts as the first
    add_visit(32'd0);
    add_visit(32'd500);
    // floor above ceiling
    add_write(CFG_FLOOR, 17'h10000);
    add_write(CFG_CEILING, 17'd1);
    add_visit(32'd600);
    // zero floor and ceiling drive the quantum to zero
    add_write(CFG_FLOOR, 17'd0);
    add_write(CFG_CEILING, 17'd0);
    add_visit(32'd700);
    add_visit(32'd800);
    // zero calibration count: every visit calibrates
    add_write(CFG_VISITS, 17'd0);
    add_write(CFG_FLOOR, 17'd1);
    add_write(CFG_CEILING, 17'h10000);
    add_write(CFG_TARGET, 17'd1);
    add_visit(32'hFFFF_FFFF);
    add_visit(32'h0000_0010);
    // longest calibration interval
    add_write(CFG_TARGET, 17'd1000);
    add_write(CFG_FLOOR, 17'd256);
    add_write(CFG_VISITS, 17'd127);
    add_visit(32'hAAAA_AAAA);
    add_visit(32'h5555_5555);

    do @(posedge clk); while (rst);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!cfg_we) settle();
        write_reg(row.index, row.value);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        offer_visit(row.stamp, row.known, row.result);
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      case (phase % 5)
        0: begin
          t = $urandom_range(1, 32767);
          f = $urandom_range(1, 4096);
          c = $urandom_range(f, 65536);
          v = $urandom_range(1, 8);
        end
        1: begin
          t = 17'd32767; f = 17'd1; c = 17'h10000; v = 17'd1;
        end
        2: begin
          t = 17'd1; f = 17'd1; c = 17'h10000; v = 17'd0;
        end
        3: begin
          t = $urandom_range(100, 2000);
          f = 17'd256;
          c = 17'h10000;
          v = $urandom_range(16, 127);
        end
        default: begin
          t = $urandom_range(1, 32767);
          f = $urandom_range(0, 65536);
          c = $urandom_range(0, 65536);
          v = $urandom_range(0, 127);
        end
      endcase
      write_reg(CFG_TARGET, t);
      write_reg(CFG_FLOOR, f);
      write_reg(CFG_CEILING, c);
      write_reg(CFG_VISITS, v);
      cfg_we <= 1'b0;
      wall = $urandom;
      for (int n = 0; n < 123; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          stamp = $urandom;
        end else if (roll < 12) begin
          stamp = wall;
        end else if (roll < 14) begin
          stamp = '0;
        end else begin
          // clock moves by roughly a quarter to four times the target per visit
          wall = wall + (CLOCK_W'(target_reg) * $urandom_range(25, 400)) / 100
                 + $urandom_range(0, 7);
          stamp = wall;
        end
        offer_visit(stamp, 1'b0, '0);
      end
    end

    // drain and let the pipeline go quiet
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("visits: %0d over %0d register settings, %0d calibrations, %0d quantum changes",
             visits_offered, settings_used, calibrations, quantum_moves);
    $display("result beats checked: %0d, mismatches: %0d", results_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: random ready pattern plus one long hold-off to back the block up
  initial begin : receiver
    int  gap;
    bit  pressure_done;
    pressure_done = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!pressure_done && results_seen >= 300) begin
        pressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (800) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 300 : 15)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    visit_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", opcode_total, '0);
      end else begin
        want = pending_results.pop_front();
        if (preload !== want.preload)
          report_mismatch("preload", 64'(preload), 64'(want.preload));
        if (quantum !== want.quantum)
          report_mismatch("quantum", 64'(quantum), 64'(want.quantum));
        if (opcode_total !== want.total)
          report_mismatch("opcode_total", opcode_total, want.total);
        if (calibrated !== want.calibrated)
          report_mismatch("calibrated", 64'(calibrated), 64'(want.calibrated));
      end
    end
  end

endmodule
